// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked and reset-qualified.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hdl/lmon_pkg.sv -----
// ---------------------------------------------------------------------------
// lmon_pkg
// Types and constants for the per-metric latency monitor.
// ---------------------------------------------------------------------------
`default_nettype none

package lmon_pkg;

  localparam int METRICS      = 6;
  localparam int WINDOW_DEPTH = 256;
  localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
  localparam int FILL_W       = WIN_AW + 1;
  localparam int MEM_DEPTH    = METRICS * WINDOW_DEPTH;
  localparam int MEM_AW       = $clog2(MEM_DEPTH);

  // x / 1000 == (x * 274877907) >> 38 for every 32-bit x
  localparam logic [28:0] DIV1000_MUL   = 29'd274877907;
  localparam int          DIV1000_SHIFT = 38;

  typedef enum logic [1:0] {
    FUNC_BEGIN = 2'd0,
    FUNC_END   = 2'd1,
    FUNC_SPAN  = 2'd2,
    FUNC_READ  = 2'd3
  } func_t;

  typedef enum logic {
    REG_FLUSH_METRIC = 1'b0,
    REG_INIT_TIME    = 1'b1
  } reg_addr_t;

  typedef struct packed {
    func_t       func;
    logic [2:0]  metric;
    logic [31:0] now_us;
    logic [31:0] span_start_us;
    logic [7:0]  window_index;
  } item_t;

  typedef struct packed {
    logic        ok;
    logic        recorded;
    logic [31:0] duration_us;
    logic [31:0] sample_count;
    logic [63:0] sum_us;
    logic [31:0] max_us;
    logic [31:0] incomplete_count;
    logic [8:0]  window_fill;
    logic [31:0] window_sample;
    logic [31:0] commit_count;
    logic [22:0] commit_time_ms;
  } result_t;

  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    logic [31:0]       data;
  } win_wr_t;

endpackage

`default_nettype wire

// ----- hdl/lmon_window.sv -----
// ---------------------------------------------------------------------------
// lmon_window
// Sample window store for all metrics: one write port, one registered read
// port, with bypass of a write that lands on the address read in that cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module lmon_window (
  input  wire logic                          clk,
  input  wire lmon_pkg::win_wr_t             wr,
  input  wire logic                          rd_en,
  input  wire logic [lmon_pkg::MEM_AW-1:0]   rd_addr,
  output logic [31:0]                        rd_data
);

  logic [31:0] mem [lmon_pkg::MEM_DEPTH];
  logic [31:0] mem_q;
  logic        fwd_hit;
  logic [31:0] fwd_data;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q    <= mem[rd_addr];
      fwd_hit  <= wr.en && (wr.addr == rd_addr);
      fwd_data <= wr.data;
    end
  end

  assign rd_data = fwd_hit ? fwd_data : mem_q;

endmodule

`default_nettype wire

// ----- hdl/latency_monitor_per_metric_core.sv -----
// ---------------------------------------------------------------------------
// latency_monitor_per_metric_core
// Per-metric latency statistics: begin/end/span recording and stat readout.
// ---------------------------------------------------------------------------
// Each accepted item beat lands in an input register; once that register
// advances, the statistics for its metric are updated and the result beat
// is loaded into the output register. One item is taken every cycle while
// the output side keeps up. The rate is set by the read-modify-write of
// the per-metric counters and the one write port of the 1536 x 32 window
// memory. The window memory read is issued when the item is accepted; its
// contents are not cleared after reset, and slots at or beyond the metric's
// fill level read back as zero.
// Metric numbers 6 and 7 return ok=0 with every other field zero and change
// nothing. Configuration sits on an APB port: word 0 is flush_metric, word 1
// is init_time_us; write them only while no beat is in flight.
// ---------------------------------------------------------------------------
`default_nettype none

module latency_monitor_per_metric_core (
  input  wire logic                clk,
  input  wire logic                rst,
  // config
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  // items
  input  wire logic                item_valid,
  output logic                     item_stall,
  input  wire lmon_pkg::item_t     item,
  // results
  output logic                     result_valid,
  input  wire logic                result_stall,
  output lmon_pkg::result_t        result
);

  localparam int FW = lmon_pkg::FILL_W;
  localparam int AW = lmon_pkg::WIN_AW;

  // ---- configuration registers ----
  logic [2:0]  flush_metric;
  logic [31:0] init_time_us;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      flush_metric <= '0;
      init_time_us <= '0;
    end else if (cfg_wr) begin
      case (lmon_pkg::reg_addr_t'(paddr[2]))
        lmon_pkg::REG_FLUSH_METRIC: flush_metric <= pwdata[2:0];
        lmon_pkg::REG_INIT_TIME:    init_time_us <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (lmon_pkg::reg_addr_t'(paddr[2]))
      lmon_pkg::REG_FLUSH_METRIC: prdata = {29'd0, flush_metric};
      lmon_pkg::REG_INIT_TIME:    prdata = init_time_us;
      default:                    prdata = '0;
    endcase
  end

  // ---- handshake: input register, then result register ----
  logic            a_valid;
  lmon_pkg::item_t a_item;
  logic            advance;
  logic            accept;

  // stage A drains when the output register is empty or being taken
  assign advance    = a_valid && (!result_valid || !result_stall);
  assign item_stall = a_valid && !advance;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (advance) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_item <= item;
    end
  end

  // ---- per-metric state ----
  logic          pend_valid [lmon_pkg::METRICS];
  logic [31:0]   pend_start [lmon_pkg::METRICS];
  logic [31:0]   count      [lmon_pkg::METRICS];
  logic [63:0]   sum        [lmon_pkg::METRICS];
  logic [31:0]   max_dur    [lmon_pkg::METRICS];
  logic [31:0]   incomplete [lmon_pkg::METRICS];
  logic [AW-1:0] head       [lmon_pkg::METRICS];
  logic [FW-1:0] fill       [lmon_pkg::METRICS];
  logic [31:0]   commits;
  logic [22:0]   last_commit;

  // ---- update for the item in stage A ----
  logic                  m_ok;
  logic [2:0]            mi;
  logic                  is_begin, is_end, is_span, is_read;
  logic                  do_rec;
  logic                  do_commit;
  logic [31:0]           dur_base;
  logic [31:0]           dur;
  logic [31:0]           count_next;
  logic [63:0]           sum_next;
  logic [31:0]           max_next;
  logic [31:0]           incomplete_next;
  logic [AW-1:0]         head_next;
  logic [FW-1:0]         fill_next;
  logic [31:0]           commits_next;
  logic [31:0]           since_init;
  logic [60:0]           ms_prod;
  logic [22:0]           last_commit_next;
  logic [31:0]           win_rd_data;
  logic [31:0]           sample;
  lmon_pkg::win_wr_t     win_wr;
  lmon_pkg::result_t     result_next;

  assign m_ok = a_item.metric < 3'(lmon_pkg::METRICS);
  assign mi   = m_ok ? a_item.metric : 3'd0;

  assign is_begin = a_item.func == lmon_pkg::FUNC_BEGIN;
  assign is_end   = a_item.func == lmon_pkg::FUNC_END;
  assign is_span  = a_item.func == lmon_pkg::FUNC_SPAN;
  assign is_read  = a_item.func == lmon_pkg::FUNC_READ;

  // a stray end (nothing pending) records nothing
  assign do_rec    = m_ok && (is_span || (is_end && pend_valid[mi]));
  assign do_commit = do_rec && is_end && (a_item.metric == flush_metric);

  assign dur_base = is_span ? a_item.span_start_us : pend_start[mi];
  assign dur      = a_item.now_us - dur_base;

  // ms since init: reciprocal multiply replaces the divide by 1000
  assign since_init = a_item.now_us - init_time_us;
  assign ms_prod    = 61'(since_init) * 61'(lmon_pkg::DIV1000_MUL);

  always_comb begin
    count_next       = count[mi];
    sum_next         = sum[mi];
    max_next         = max_dur[mi];
    incomplete_next  = incomplete[mi];
    head_next        = head[mi];
    fill_next        = fill[mi];
    commits_next     = commits;
    last_commit_next = last_commit;
    if (do_rec) begin
      count_next = count[mi] + 32'd1;
      sum_next   = sum[mi] + {32'd0, dur};
      if (dur > max_dur[mi]) begin
        max_next = dur;
      end
      head_next = head[mi] + AW'(1);
      if (fill[mi] < FW'(lmon_pkg::WINDOW_DEPTH)) begin
        fill_next = fill[mi] + FW'(1);
      end
    end
    if (m_ok && is_begin && pend_valid[mi]) begin
      incomplete_next = incomplete[mi] + 32'd1;
    end
    if (do_commit) begin
      commits_next     = commits + 32'd1;
      last_commit_next = 23'(ms_prod >> lmon_pkg::DIV1000_SHIFT);
    end
  end

  // the recorded sample goes into the metric's ring slot
  always_comb begin
    win_wr.en   = advance && do_rec;
    win_wr.addr = {mi, head[mi]};
    win_wr.data = dur;
  end

  lmon_window u_window (
    .clk     (clk),
    .wr      (win_wr),
    .rd_en   (accept && (item.metric < 3'(lmon_pkg::METRICS))),
    .rd_addr ({item.metric, item.window_index}),
    .rd_data (win_rd_data)
  );

  // unfilled slots read as zero, so unwritten memory is never exposed
  assign sample = (is_read && ({1'b0, a_item.window_index} < fill[mi])) ?
                  win_rd_data : 32'd0;

  always_comb begin
    result_next = '0;
    if (m_ok) begin
      result_next.ok               = 1'b1;
      result_next.recorded         = do_rec;
      result_next.duration_us      = do_rec ? dur : 32'd0;
      result_next.sample_count     = count_next;
      result_next.sum_us           = sum_next;
      result_next.max_us           = max_next;
      result_next.incomplete_count = incomplete_next;
      result_next.window_fill      = fill_next;
      result_next.window_sample    = sample;
      result_next.commit_count     = commits_next;
      result_next.commit_time_ms   = last_commit_next;
    end
  end

  // ---- state write-back ----
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lmon_pkg::METRICS; i++) begin
        pend_valid[i] <= 1'b0;
        pend_start[i] <= '0;
        count[i]      <= '0;
        sum[i]        <= '0;
        max_dur[i]    <= '0;
        incomplete[i] <= '0;
        head[i]       <= '0;
        fill[i]       <= '0;
      end
      commits     <= '0;
      last_commit <= '0;
    end else if (advance && m_ok) begin
      if (is_begin) begin
        pend_valid[mi] <= 1'b1;
        pend_start[mi] <= a_item.now_us;
      end else if (is_end) begin
        pend_valid[mi] <= 1'b0;
      end
      count[mi]      <= count_next;
      sum[mi]        <= sum_next;
      max_dur[mi]    <= max_next;
      incomplete[mi] <= incomplete_next;
      head[mi]       <= head_next;
      fill[mi]       <= fill_next;
      commits        <= commits_next;
      last_commit    <= last_commit_next;
    end
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/lmon_checker.sv -----
// ---------------------------------------------------------------------------
// lmon_checker
// Port-level checks on result beats of the latency monitor.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lmon_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              result_valid,
  input wire logic              result_stall,
  input wire lmon_pkg::result_t result
);

  // a stalled result beat is held
  `ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall, result_valid && $stable(result))

  // an ignored metric reports nothing
  `ASSERT_IMPLY(a_bad_metric_zero, clk, rst, result_valid && !result.ok, !result.recorded && (result.sample_count == 32'd0) && (result.sum_us == 64'd0) && (result.window_fill == 9'd0) && (result.commit_count == 32'd0))

  // duration only when a sample was recorded
  `ASSERT_IMPLY(a_dur_only_rec, clk, rst, result_valid && !result.recorded, result.duration_us == 32'd0)

  // a recorded sample never exceeds the running maximum
  `ASSERT_IMPLY(a_max_covers, clk, rst, result_valid && result.recorded, (result.max_us >= result.duration_us) && (result.window_fill != 9'd0))

  // window never overfills
  `ASSERT_IMPLY(a_fill_range, clk, rst, result_valid, result.window_fill <= 9'd256)

endmodule

bind latency_monitor_per_metric_core lmon_checker u_lmon_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire
